// ----- hdl/dpfk_pkg.sv -----
// Package for the DPF key generator: payload and job types, word kinds,
// register indexes, the AES S-box, round function and fixed key schedule.
// No dependencies.
package dpfk_pkg;

  localparam int IDX_W   = 43;
  localparam int DEPTH_W = 6;
  localparam int GRP_W   = 5;
  localparam int NUM_W   = 5;
  localparam int PATH_W  = 32;
  localparam int QUOT_W  = IDX_W - 7;

  localparam int DEF_MAX_DEPTH = 32;
  localparam int DEF_MAX_GROUP = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd8;
  localparam logic [GRP_W-1:0]   GRP_RESET   = 5'd1;

  localparam logic CFG_TREE_DEPTH   = 1'b0;
  localparam logic CFG_GROUP_BLOCKS = 1'b1;

  localparam logic [1:0] KIND_ROOT0 = 2'd0;
  localparam logic [1:0] KIND_ROOT1 = 2'd1;
  localparam logic [1:0] KIND_LEVEL = 2'd2;
  localparam logic [1:0] KIND_GROUP = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] target_index;
    logic [63:0]      rand_a_low;
    logic [63:0]      rand_a_high;
    logic [63:0]      rand_b_low;
    logic [63:0]      rand_b_high;
  } request_t;

  typedef struct packed {
    logic [1:0]       word_kind;
    logic [NUM_W-1:0] word_number;
    logic [63:0]      word_low;
    logic [63:0]      word_high;
    logic             last_word;
  } result_t;

  typedef struct packed {
    logic [127:0]       seed0;
    logic [127:0]       seed1;
    logic [PATH_W-1:0]  path;
    logic [DEPTH_W-1:0] depth;
    logic [GRP_W-1:0]   grp;
    logic [GRP_W-1:0]   flip_word;
    logic [6:0]         flip_bit;
  } job_t;

  typedef struct packed {
    logic         start;
    logic         key_sel;
    logic [127:0] block;
  } aes_cmd_t;

  typedef logic [10:0][127:0] rk_set_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic rk_set_t key_schedule(input logic [7:0] key_byte);
    logic [175:0][7:0] rk;
    logic [7:0] t0, t1, t2, t3, x;
    rk_set_t ks;
    rk = '0;
    rk[0] = key_byte;
    for (int i = 16; i < 176; i += 4) begin
      t0 = rk[i-4];
      t1 = rk[i-3];
      t2 = rk[i-2];
      t3 = rk[i-1];
      if ((i % 16) == 0) begin
        x  = t0;
        t0 = SBOX[t1] ^ RCON[i/16];
        t1 = SBOX[t2];
        t2 = SBOX[t3];
        t3 = SBOX[x];
      end
      rk[i]   = rk[i-16] ^ t0;
      rk[i+1] = rk[i-15] ^ t1;
      rk[i+2] = rk[i-14] ^ t2;
      rk[i+3] = rk[i-13] ^ t3;
    end
    for (int r = 0; r < 11; r++) begin
      for (int b = 0; b < 16; b++) begin
        ks[r][8*b +: 8] = rk[16*r + b];
      end
    end
    return ks;
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         last);
    logic [15:0][7:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = SBOX[s[8*(i + 4*((c + i) % 4)) +: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        a1  = t[4*c+1];
        a2  = t[4*c+2];
        a3  = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

endpackage

// ----- hdl/dpf_key_generator.sv -----
// Top level of the DPF key generator: configuration registers, front end,
// job queue and key sequencer. Depends on dpfk_pkg and the dpfk_* modules.
//
// Usage:
//   Request channel: a transaction is taken at a clock edge with start high
//   and busy low. The front end then divides the index by the group size
//   and hands the job to a two-entry queue; busy stays high until the job
//   is queued.
//   Result channel: result_valid marks each result word for one cycle. Per
//   request the words are root seed 0, root seed 1, tree_depth level words
//   and group_blocks group words; last_word marks the final one.
//   The back end runs one shared AES unit, one round per cycle, and runs
//   its encryptions one at a time, so a request's time in the back end is
//   set by the AES round loop.
//   The front end takes the next request while the back end works.
//   Configuration: cfg_we writes register cfg_index (0 tree_depth,
//   1 group_blocks) from cfg_data; write only while idle.
//   Reset (rst, synchronous) empties the queue, idles both ends and loads
//   tree_depth 8 and group_blocks 1. The receiver cannot stall results.
module dpf_key_generator #(
  parameter int MAX_DEPTH = dpfk_pkg::DEF_MAX_DEPTH,
  parameter int MAX_GROUP = dpfk_pkg::DEF_MAX_GROUP
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  dpfk_pkg::request_t         request,
  output logic                       result_valid,
  output dpfk_pkg::result_t          result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [dpfk_pkg::DEPTH_W-1:0] cfg_data
);
  import dpfk_pkg::*;

  logic [DEPTH_W-1:0] depth_cfg;
  logic [GRP_W-1:0]   grp_cfg;
  logic               push, pop, q_full, q_empty;
  job_t               wr_job, rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_cfg <= DEPTH_RESET;
      grp_cfg   <= GRP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TREE_DEPTH:   depth_cfg <= cfg_data;
        CFG_GROUP_BLOCKS: grp_cfg   <= cfg_data[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  dpfk_front #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_GROUP (MAX_GROUP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .depth_cfg (depth_cfg),
    .grp_cfg   (grp_cfg),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  dpfk_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  dpfk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_job        (rd_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- hdl/dpfk_aes.sv -----
// Iterative fixed-key AES-128 unit, one round per cycle, with the
// Matyas-Meyer-Oseas feed-forward. Depends on dpfk_pkg.
module dpfk_aes (
  input  logic              clk,
  input  logic              rst,
  input  dpfk_pkg::aes_cmd_t cmd,
  output logic              done,
  output logic [127:0]      digest
);
  import dpfk_pkg::*;

  localparam rk_set_t RK0 = key_schedule(8'h00);
  localparam rk_set_t RK1 = key_schedule(8'h01);

  logic [127:0] st;
  logic [127:0] xin;
  logic [3:0]   rnd;
  logic         run;
  logic         sel;
  logic [127:0] rk;

  assign rk     = sel ? RK1[rnd] : RK0[rnd];
  assign digest = st ^ xin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      rnd  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        st  <= cmd.block ^ (cmd.key_sel ? RK1[0] : RK0[0]);
        xin <= cmd.block;
        sel <= cmd.key_sel;
        rnd <= 4'd1;
        run <= 1'b1;
      end else if (run) begin
        st <= aes_round(st, rk, rnd == 4'd10);
        if (rnd == 4'd10) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          rnd <= rnd + 4'd1;
        end
      end
    end
  end

endmodule

// ----- hdl/dpfk_front.sv -----
// Front end: takes a request, fixes the seed parity and splits the index into
// leaf path and group bit by a serial divide. Depends on dpfk_pkg.
module dpfk_front #(
  parameter int MAX_DEPTH = dpfk_pkg::DEF_MAX_DEPTH,
  parameter int MAX_GROUP = dpfk_pkg::DEF_MAX_GROUP
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  dpfk_pkg::request_t         request,
  input  logic [dpfk_pkg::DEPTH_W-1:0] depth_cfg,
  input  logic [dpfk_pkg::GRP_W-1:0]   grp_cfg,
  input  logic                       q_full,
  output logic                       push,
  output dpfk_pkg::job_t             job
);
  import dpfk_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]         state;
  logic [5:0]         cnt;
  logic [QUOT_W-1:0]  dv;
  logic [GRP_W-1:0]   rem;
  logic [127:0]       seed0, seed1;
  logic [DEPTH_W-1:0] depth;
  logic [GRP_W-1:0]   grp;
  logic [6:0]         low_idx;
  logic [DEPTH_W-1:0] depth_clamp;
  logic [GRP_W-1:0]   grp_clamp;
  logic [GRP_W:0]     rem_t;
  logic               ge;
  logic [DEPTH_W-1:0] shamt;

  always_comb begin
    depth_clamp = depth_cfg;
    if (depth_cfg == '0) depth_clamp = DEPTH_W'(1);
    else if (depth_cfg > DEPTH_W'(MAX_DEPTH)) depth_clamp = DEPTH_W'(MAX_DEPTH);
    grp_clamp = grp_cfg;
    if (grp_cfg == '0) grp_clamp = GRP_W'(1);
    else if (grp_cfg > GRP_W'(MAX_GROUP)) grp_clamp = GRP_W'(MAX_GROUP);
  end

  assign rem_t = {rem, dv[QUOT_W-1]};
  assign ge    = rem_t >= {1'b0, grp};
  assign shamt = DEPTH_W'(PATH_W) - depth;

  assign busy = state != F_IDLE;
  assign push = (state == F_PUSH) && !q_full;

  always_comb begin
    job.seed0     = seed0;
    job.seed1     = seed1;
    job.path      = dv[PATH_W-1:0] << shamt[4:0];
    job.depth     = depth;
    job.grp       = grp;
    job.flip_word = rem;
    job.flip_bit  = {low_idx[3:0], low_idx[6:4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            dv      <= request.target_index[IDX_W-1:7];
            low_idx <= request.target_index[6:0];
            rem     <= '0;
            cnt     <= '0;
            seed1   <= {request.rand_b_high, request.rand_b_low};
            seed0   <= {request.rand_a_high, request.rand_a_low[63:1],
                        ~request.rand_b_low[0]};
            depth   <= depth_clamp;
            grp     <= grp_clamp;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= ge ? GRP_W'(rem_t - {1'b0, grp}) : rem_t[GRP_W-1:0];
          dv  <= {dv[QUOT_W-2:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QUOT_W - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/dpfk_queue.sv -----
// Two-entry job queue between the front end and the key sequencer.
// Depends on dpfk_pkg.
module dpfk_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpfk_pkg::job_t wr_job,
  input  logic           pop,
  output dpfk_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);
  import dpfk_pkg::*;

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full   = count == 2'd2;
  assign empty  = count == 2'd0;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/dpfk_back.sv -----
// Key sequencer: walks the tree for one job through the shared AES unit and
// emits root seeds, level words and group words. Depends on dpfk_pkg, dpfk_aes.
module dpfk_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  dpfk_pkg::job_t    q_job,
  output logic              pop,
  output logic              result_valid,
  output dpfk_pkg::result_t result
);
  import dpfk_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_ROOT0 = 4'd1;
  localparam logic [3:0] B_ROOT1 = 4'd2;
  localparam logic [3:0] B_LENC  = 4'd3;
  localparam logic [3:0] B_LWAIT = 4'd4;
  localparam logic [3:0] B_LOUT  = 4'd5;
  localparam logic [3:0] B_GENC  = 4'd6;
  localparam logic [3:0] B_GWAIT = 4'd7;
  localparam logic [3:0] B_GOUT  = 4'd8;

  logic [3:0]   state;
  job_t         job;
  logic [127:0] s0, s1;
  logic [PATH_W-1:0] path;
  logic [NUM_W-1:0]  lvl;
  logic [GRP_W-1:0]  gcnt;
  logic [1:0]   enc;
  logic [127:0] c [4];
  aes_cmd_t     cmd;
  logic         done;
  logic [127:0] digest;

  logic         keep;
  logic [127:0] x0, x1, scw, cw, n0, n1, gw;
  logic         tl, tr, tk;

  dpfk_aes u_aes (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .done   (done),
    .digest (digest)
  );

  assign pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    keep = path[PATH_W-1];
    x0   = c[0] ^ c[2];
    x1   = c[1] ^ c[3];
    tl   = x0[0] ^ keep ^ 1'b1;
    tr   = x1[0] ^ keep;
    tk   = keep ? tr : tl;
    scw  = keep ? {x0[127:2], 2'b00} : {x1[127:2], 2'b00};
    cw   = {scw[127:2], tl, tr};
    n0   = (keep ? c[1] : c[0]) ^ (s0[0] ? (scw ^ {127'b0, tk}) : 128'b0);
    n1   = (keep ? c[3] : c[2]) ^ (s1[0] ? (scw ^ {127'b0, tk}) : 128'b0);
    gw   = c[0] ^ c[1];
    if (gcnt == job.flip_word) gw[job.flip_bit] = ~gw[job.flip_bit];
  end

  always_comb begin
    cmd = '0;
    if (state == B_LENC) begin
      cmd.start   = 1'b1;
      cmd.key_sel = enc[0];
      cmd.block   = enc[1] ? {s1[127:2], 2'b00} : {s0[127:2], 2'b00};
    end else if (state == B_GENC) begin
      cmd.start   = 1'b1;
      cmd.key_sel = 1'b0;
      cmd.block   = (enc[0] ? {s1[127:2], 2'b00} : {s0[127:2], 2'b00})
                    ^ {123'b0, gcnt};
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LWAIT && done) c[enc] <= digest;
    if (state == B_GWAIT && done) c[enc] <= digest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      enc          <= '0;
      lvl          <= '0;
      gcnt         <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            s0    <= q_job.seed0;
            s1    <= q_job.seed1;
            path  <= q_job.path;
            state <= B_ROOT0;
          end
        end
        B_ROOT0: begin
          result_valid <= 1'b1;
          result       <= {KIND_ROOT0, NUM_W'(0), s0[63:0], s0[127:64], 1'b0};
          state        <= B_ROOT1;
        end
        B_ROOT1: begin
          result_valid <= 1'b1;
          result       <= {KIND_ROOT1, NUM_W'(0), s1[63:0], s1[127:64], 1'b0};
          lvl          <= '0;
          enc          <= '0;
          state        <= B_LENC;
        end
        B_LENC: state <= B_LWAIT;
        B_LWAIT: begin
          if (done) begin
            enc   <= enc + 2'd1;
            state <= (enc == 2'd3) ? B_LOUT : B_LENC;
          end
        end
        B_LOUT: begin
          result_valid <= 1'b1;
          result       <= {KIND_LEVEL, lvl, cw[63:0], cw[127:64], 1'b0};
          s0           <= n0;
          s1           <= n1;
          path         <= {path[PATH_W-2:0], 1'b0};
          lvl          <= lvl + NUM_W'(1);
          enc          <= '0;
          gcnt         <= '0;
          state        <= (DEPTH_W'(lvl) == job.depth - DEPTH_W'(1)) ? B_GENC : B_LENC;
        end
        B_GENC: state <= B_GWAIT;
        B_GWAIT: begin
          if (done) begin
            enc   <= {1'b0, ~enc[0]};
            state <= enc[0] ? B_GOUT : B_GENC;
          end
        end
        B_GOUT: begin
          result_valid <= 1'b1;
          result       <= {KIND_GROUP, NUM_W'(gcnt), gw[63:0], gw[127:64],
                           gcnt == job.grp - GRP_W'(1)};
          gcnt         <= gcnt + GRP_W'(1);
          enc          <= '0;
          state        <= (gcnt == job.grp - GRP_W'(1)) ? B_IDLE : B_GENC;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/dpfk_checker.sv -----
// Port-level checks for the DPF key generator and the bind that attaches
// them. Depends on dpfk_pkg and dpf_key_generator.
module dpfk_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input dpfk_pkg::result_t result
);
  import dpfk_pkg::*;

  a_root_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.word_kind == KIND_ROOT0
    |=> result_valid && result.word_kind == KIND_ROOT1)
    else $error("root seed 1 does not follow root seed 0");

  a_root_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.word_kind == KIND_ROOT0 || result.word_kind == KIND_ROOT1)
    |-> !result.last_word && result.word_number == '0)
    else $error("root seed word malformed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("front end not busy after a transaction");

  a_last_group: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_word |-> result.word_kind == KIND_GROUP)
    else $error("last word is not a group word");

endmodule

bind dpf_key_generator dpfk_checker u_dpfk_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
